// File: hdl/cdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_GUARD   = 24;
    localparam int TABLE_LEN    = 24;

    // Datapath width of the vectoring pipeline and of its angle accumulator.
    localparam int DATA_W  = 60;
    localparam int ANGLE_W = 34;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    localparam logic [31:0] TURN_ATAN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                 is_zero;
        logic [FRAC_BITS-1:0] hue;
    } tag_t;

endpackage

`default_nettype wire

// File: hdl/cdc_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module cdc_cordic
    import cdc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic signed [DATA_W-1:0]  in_x,
    input  wire logic signed [DATA_W-1:0]  in_y,
    input  wire logic signed [ANGLE_W-1:0] in_acc,
    input  wire tag_t                      in_tag,
    output logic                           out_valid,
    output logic signed [DATA_W-1:0]       out_x,
    output logic signed [ANGLE_W-1:0]      out_acc,
    output tag_t                           out_tag
);

    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic                      valid_reg [STEPS+1];
    logic signed [DATA_W-1:0]  x_reg     [STEPS+1];
    logic signed [DATA_W-1:0]  y_reg     [STEPS+1];
    logic signed [ANGLE_W-1:0] acc_reg   [STEPS+1];
    tag_t                      tag_reg   [STEPS+1];

    assign valid_reg[0] = in_valid;
    assign x_reg[0]     = in_x;
    assign y_reg[0]     = in_y;
    assign acc_reg[0]   = in_acc;
    assign tag_reg[0]   = in_tag;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [ANGLE_W-1:0] ANGLE =
            ANGLE_W'(signed'({1'b0, TURN_ATAN[i]}));
        logic signed [DATA_W-1:0]  x_next;
        logic signed [DATA_W-1:0]  y_next;
        logic signed [ANGLE_W-1:0] acc_next;

        always_comb
        begin
            if (y_reg[i] >= 0)
            begin
                x_next   = x_reg[i] + (y_reg[i] >>> i);
                y_next   = y_reg[i] - (x_reg[i] >>> i);
                acc_next = acc_reg[i] + ANGLE;
            end
            else
            begin
                x_next   = x_reg[i] - (y_reg[i] >>> i);
                y_next   = y_reg[i] + (x_reg[i] >>> i);
                acc_next = acc_reg[i] - ANGLE;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]   <= x_next;
            y_reg[i+1]   <= y_next;
            acc_reg[i+1] <= acc_next;
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_x     = x_reg[STEPS];
    assign out_acc   = acc_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

endmodule

`default_nettype wire

// File: hdl/complex_domain_color_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps one complex sample to an RGB pixel by domain coloring. One sample is
// taken in every cycle (busy is always low), and its pixel appears on red,
// green and blue with done high for one cycle, after the input register, a
// CORDIC vectoring pass, two gain registers, a second pass, and lightness,
// chroma, xc and output registers. The receiver cannot stall the pipeline.

module complex_domain_color_pixel
    import cdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] real_part,
    input  wire logic signed [31:0] imag_part,
    output logic                    done,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue
);

    localparam int F = FRAC_BITS;
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    localparam int HALF_POS = 31 - F;

    // Input stage with half-plane fold.
    logic                      s0_valid_reg;
    logic signed [DATA_W-1:0]  s0_x_reg, s0_x_next;
    logic signed [DATA_W-1:0]  s0_y_reg, s0_y_next;
    logic signed [ANGLE_W-1:0] s0_acc_reg, s0_acc_next;
    tag_t                      s0_tag_reg, s0_tag_next;

    always_comb
    begin
        s0_x_next   = DATA_W'(real_part);
        s0_y_next   = DATA_W'(imag_part);
        s0_acc_next = '0;
        if (real_part < 0)
        begin
            s0_acc_next = (imag_part >= 0) ? ANGLE_W'(signed'(35'sh080000000))
                                           : ANGLE_W'(-35'sh080000000);
            s0_x_next   = -s0_x_next;
            s0_y_next   = -s0_y_next;
        end
        s0_tag_next.is_zero = (real_part == 0) && (imag_part == 0);
        s0_tag_next.hue     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_x_reg   <= s0_x_next;
        s0_y_reg   <= s0_y_next;
        s0_acc_reg <= s0_acc_next;
        s0_tag_reg <= s0_tag_next;
    end

    assign busy = 1'b0;

    // First pass: angle and scaled magnitude of z.
    logic                      c1_valid;
    logic signed [DATA_W-1:0]  c1_x;
    logic signed [ANGLE_W-1:0] c1_acc;
    tag_t                      c1_tag;

    cdc_cordic u_arg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_x      (s0_x_reg),
        .in_y      (s0_y_reg),
        .in_acc    (s0_acc_reg),
        .in_tag    (s0_tag_reg),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_acc   (c1_acc),
        .out_tag   (c1_tag)
    );

    // Gain correction as two partial products; hue rounding alongside.
    logic              m1_valid_reg;
    logic [46:0]       m1_lo_reg, m1_lo_next;
    logic [46:0]       m1_hi_reg, m1_hi_next;
    tag_t              m1_tag_reg, m1_tag_next;
    logic [33:0]       xpos;
    logic signed [35:0] hq;
    logic [32:0]       hq_clamped;
    logic [33:0]       hue_sum;
    logic [F+1:0]      hue_full;

    always_comb
    begin
        xpos = (c1_x < 0) ? '0 : c1_x[33:0];
        m1_lo_next = 47'(xpos[16:0]) * 47'(INV_GAIN_Q30);
        m1_hi_next = 47'(xpos[33:17]) * 47'(INV_GAIN_Q30);
        hq = 36'(c1_acc) + 36'sh080000000;
        if (hq < 0)
        begin
            hq_clamped = '0;
        end
        else if (hq > 36'sh100000000)
        begin
            hq_clamped = 33'h100000000;
        end
        else
        begin
            hq_clamped = hq[32:0];
        end
        hue_sum  = 34'(hq_clamped) + (34'(1) << HALF_POS);
        hue_full = hue_sum[33:32-F];
        m1_tag_next.is_zero = c1_tag.is_zero;
        m1_tag_next.hue     = (hue_full >= (F+2)'(ONE)) ? '0 : hue_full[F-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_lo_reg  <= m1_lo_next;
        m1_hi_reg  <= m1_hi_next;
        m1_tag_reg <= m1_tag_next;
    end

    logic        m2_valid_reg;
    logic [33:0] m2_mag_reg, m2_mag_next;
    tag_t        m2_tag_reg;
    logic [63:0] mag_sum;

    always_comb
    begin
        mag_sum     = (64'(m1_hi_reg) << 17) + 64'(m1_lo_reg);
        m2_mag_next = mag_sum[63:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_mag_reg <= m2_mag_next;
        m2_tag_reg <= m1_tag_reg;
    end

    // Second pass: atan(|z|) from the vector (1, |z|).
    logic signed [DATA_W-1:0]  c2_x_in;
    logic signed [DATA_W-1:0]  c2_y_in;
    logic                      c2_valid;
    logic signed [DATA_W-1:0]  c2_x;
    logic signed [ANGLE_W-1:0] c2_acc;
    tag_t                      c2_tag;

    assign c2_x_in = DATA_W'(1) << (F + ATAN_GUARD);
    assign c2_y_in = DATA_W'(m2_mag_reg) << ATAN_GUARD;

    cdc_cordic u_atan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid_reg),
        .in_x      (c2_x_in),
        .in_y      (c2_y_in),
        .in_acc    ('0),
        .in_tag    (m2_tag_reg),
        .out_valid (c2_valid),
        .out_x     (c2_x),
        .out_acc   (c2_acc),
        .out_tag   (c2_tag)
    );

    // Lightness.
    logic             h1_valid_reg;
    logic [F-1:0]     h1_light_reg, h1_light_next;
    logic [F-1:0]     h1_hue_reg;
    logic [ANGLE_W:0] lq;
    logic [ANGLE_W+1:0] light_sum;
    logic [ANGLE_W+1-(32-F):0] light_full;

    always_comb
    begin
        lq = c2_acc[ANGLE_W-1] ? '0 : {c2_acc[ANGLE_W-2:0], 2'b00};
        light_sum  = (ANGLE_W+2)'(lq) + ((ANGLE_W+2)'(1) << HALF_POS);
        light_full = light_sum[ANGLE_W+1:32-F];
        if (light_full > (ANGLE_W+2-(32-F))'(ONE - 1'b1))
        begin
            h1_light_next = '1;
        end
        else
        begin
            h1_light_next = light_full[F-1:0];
        end
        if (c2_tag.is_zero)
        begin
            h1_light_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg <= 1'b0;
        end
        else
        begin
            h1_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        h1_light_reg <= h1_light_next;
        h1_hue_reg   <= c2_tag.hue;
    end

    // Chroma, sextant and position within the sextant.
    logic         h2_valid_reg;
    logic [F:0]   h2_chroma_reg, h2_chroma_next;
    logic [F:0]   h2_omd_reg, h2_omd_next;
    logic [F:0]   h2_m2_reg, h2_m2_next;
    logic [2:0]   h2_sext_reg, h2_sext_next;
    logic [F:0]   two_l;
    logic [F+2:0] hue6;
    logic [F:0]   t;
    logic [F:0]   hue_dist;

    always_comb
    begin
        two_l = {h1_light_reg, 1'b0};
        if (two_l >= ONE)
        begin
            h2_chroma_next = ONE - (two_l - ONE);
        end
        else
        begin
            h2_chroma_next = two_l;
        end
        h2_m2_next   = two_l - h2_chroma_next;
        hue6         = ((F+3)'(h1_hue_reg) << 2) + ((F+3)'(h1_hue_reg) << 1);
        t            = hue6[F:0];
        hue_dist     = (t >= ONE) ? t - ONE : ONE - t;
        h2_omd_next  = ONE - hue_dist;
        h2_sext_next = hue6[F+2:F];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h2_valid_reg <= 1'b0;
        end
        else
        begin
            h2_valid_reg <= h1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h2_chroma_reg <= h2_chroma_next;
        h2_omd_reg    <= h2_omd_next;
        h2_m2_reg     <= h2_m2_next;
        h2_sext_reg   <= h2_sext_next;
    end

    // Second largest component.
    logic         h3_valid_reg;
    logic [F:0]   h3_xc_reg, h3_xc_next;
    logic [F:0]   h3_chroma_reg;
    logic [F:0]   h3_m2_reg;
    logic [2:0]   h3_sext_reg;
    logic [2*F+1:0] xc_prod;

    always_comb
    begin
        xc_prod    = (2*F+2)'(h2_chroma_reg) * (2*F+2)'(h2_omd_reg);
        h3_xc_next = xc_prod[2*F:F];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h3_valid_reg <= 1'b0;
        end
        else
        begin
            h3_valid_reg <= h2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h3_xc_reg     <= h3_xc_next;
        h3_chroma_reg <= h2_chroma_reg;
        h3_m2_reg     <= h2_m2_reg;
        h3_sext_reg   <= h2_sext_reg;
    end

    // Sextant selection and byte conversion.
    function automatic logic [7:0] to_byte(input logic [F:0] c, input logic [F:0] m2);
        logic [F+2:0]  c2;
        logic [F+10:0] scaled;
        logic [9:0]    v;
        c2     = ((F+3)'(c) << 1) + (F+3)'(m2);
        scaled = ((F+11)'(c2) << 8) - (F+11)'(c2);
        v      = scaled[F+10:F+1];
        return (v > 10'd255) ? 8'hFF : v[7:0];
    endfunction

    logic       done_reg;
    logic [7:0] red_reg, red_next;
    logic [7:0] green_reg, green_next;
    logic [7:0] blue_reg, blue_next;
    logic [F:0] r_sel, g_sel, b_sel;

    always_comb
    begin
        case (h3_sext_reg)
            3'd0:
            begin
                r_sel = h3_chroma_reg; g_sel = h3_xc_reg;     b_sel = '0;
            end
            3'd1:
            begin
                r_sel = h3_xc_reg;     g_sel = h3_chroma_reg; b_sel = '0;
            end
            3'd2:
            begin
                r_sel = '0;            g_sel = h3_chroma_reg; b_sel = h3_xc_reg;
            end
            3'd3:
            begin
                r_sel = '0;            g_sel = h3_xc_reg;     b_sel = h3_chroma_reg;
            end
            3'd4:
            begin
                r_sel = h3_xc_reg;     g_sel = '0;            b_sel = h3_chroma_reg;
            end
            default:
            begin
                r_sel = h3_chroma_reg; g_sel = '0;            b_sel = h3_xc_reg;
            end
        endcase
        red_next   = to_byte(r_sel, h3_m2_reg);
        green_next = to_byte(g_sel, h3_m2_reg);
        blue_next  = to_byte(b_sel, h3_m2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= h3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire
